// ===== rtl/core/set_associative_lru_cache_model_defines.svh =====
// Assertion helpers for the checker file salru_chk.sv.
`ifndef SET_ASSOCIATIVE_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_MODEL_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define SALRU_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high
`define SALRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds around reset
`define SALRU_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/salru_pkg.sv =====
`default_nettype none
package salru_pkg;

  // Geometry
  localparam int MAX_SET_BITS = 6;
  localparam int WAYS         = 8;
  localparam int STAMP_BITS   = 32;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W       = $clog2(WAYS + 1);

  // Field widths
  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int OP_W       = 2;
  localparam int OUTCOME_W  = 2;
  localparam int OUT_WAY_W  = 3;
  localparam int CNT_W      = 32;
  localparam int SB_W       = 3;
  localparam int BB_W       = 6;
  localparam int WIU_W      = 4;
  localparam int SHIFT_W    = BB_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Access queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  // One cache access handed from front to back
  typedef struct packed {
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    logic             last;
  } access_t;

  // Contents of one line in the line RAM
  typedef struct packed {
    logic                  valid;
    logic [TAG_W-1:0]      tag;
    logic [STAMP_BITS-1:0] stamp;
  } line_t;

  localparam int LINE_W = $bits(line_t);

endpackage
`default_nettype wire

// ===== rtl/core/salru_req_if.sv =====
`default_nettype none
interface salru_req_if;
  import salru_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink (input valid, input op, input address, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/salru_res_if.sv =====
`default_nettype none
interface salru_res_if;
  import salru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [OUT_WAY_W-1:0] way_used;
  logic [CNT_W-1:0]     hits_so_far;
  logic [CNT_W-1:0]     misses_so_far;
  logic [CNT_W-1:0]     evictions_so_far;
  logic                 last;

  modport source (output valid, output outcome, output way_used, output hits_so_far,
                  output misses_so_far, output evictions_so_far, output last,
                  input ready);
  modport sink (input valid, input outcome, input way_used, input hits_so_far,
                input misses_so_far, input evictions_so_far, input last,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/salru_cfg_if.sv =====
`default_nettype none
interface salru_cfg_if;
  import salru_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/salru_ram.sv =====
`default_nettype none
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/salru_fifo.sv =====
`default_nettype none
module salru_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  salru_pkg::access_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output salru_pkg::access_t pop_data
);
  import salru_pkg::*;

  access_t           entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/salru_front.sv =====
`default_nettype none
module salru_front (
  input  logic                        clk,
  input  logic                        rst,
  salru_req_if.sink                   req,
  input  logic [salru_pkg::SB_W-1:0]  set_bits,
  input  logic [salru_pkg::BB_W-1:0]  block_bits,
  output logic                        push_valid,
  input  logic                        push_ready,
  output salru_pkg::access_t          push_data
);
  import salru_pkg::*;

  logic               held_valid;
  logic [OP_W-1:0]    held_op;
  logic [ADDR_W-1:0]  held_addr;
  logic               second;
  logic               drop;
  logic               last_access;
  logic               done;
  logic [SB_W-1:0]    sb_eff;
  logic [SHIFT_W-1:0] shift;
  logic [SET_W-1:0]   set_mask;
  logic [ADDR_W-1:0]  above_block;

  // Classify the held item
  always_comb begin
    drop        = 1'b0;
    last_access = 1'b1;
    unique case (held_op)
      OP_LOAD, OP_STORE: last_access = 1'b1;
      OP_MODIFY:         last_access = second;
      default:           drop = 1'b1;
    endcase
  end

  // Split the address into set index and tag
  always_comb begin
    sb_eff      = (int'(set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : set_bits;
    shift       = SHIFT_W'(sb_eff) + SHIFT_W'(block_bits);
    set_mask    = ~({SET_W{1'b1}} << sb_eff);
    above_block = held_addr >> block_bits;
  end

  assign push_valid         = held_valid && !drop;
  assign push_data.set_idx  = above_block[SET_W-1:0] & set_mask;
  assign push_data.tag      = (shift >= SHIFT_W'(ADDR_W)) ? '0 : (held_addr >> shift);
  assign push_data.last     = last_access;

  assign done      = held_valid && (drop || (push_ready && last_access));
  assign req.ready = !held_valid || done;

  // Hold register control
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      second     <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        held_valid <= 1'b1;
        second     <= 1'b0;
      end else if (done) begin
        held_valid <= 1'b0;
      end else if (push_valid && push_ready) begin
        second <= 1'b1;
      end
    end
  end

  // Hold register payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      held_op   <= req.op;
      held_addr <= req.address;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/salru_back.sv =====
`default_nettype none
module salru_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [salru_pkg::WIU_W-1:0]  ways_in_use,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  salru_pkg::access_t           head,
  salru_res_if.source                  res
);
  import salru_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_CLEAR  = 2'd3;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [WCNT_W-1:0]     ways_eff;
  logic [WAYS-1:0]       in_use;

  // Clearing pass after reset
  logic                  clearing;
  logic [SET_W-1:0]      clear_idx;
  logic [SET_W-1:0]      ram_waddr;
  line_t                 ram_wdata;

  // Access being looked up
  logic [SET_W-1:0]      e_set;
  logic [TAG_W-1:0]      e_tag;
  logic                  e_last;
  logic [LINE_W-1:0]     rd_raw [WAYS];
  logic [WAYS-1:0]       e_match;
  logic [WAYS-1:0]       e_empty;
  logic [STAMP_BITS-1:0] e_age [WAYS];

  // Access being decided
  logic [SET_W-1:0]      d_set;
  logic [TAG_W-1:0]      d_tag;
  logic                  d_last;
  logic [WAYS-1:0]       d_match;
  logic [WAYS-1:0]       d_empty;
  logic [WAYS-1:0]       d_in_use;
  logic [STAMP_BITS-1:0] d_age [WAYS];

  // Line written in the previous cycle, for read-during-write bypass
  logic                  fwd_valid;
  logic [SET_W-1:0]      fwd_set;
  logic [WAY_W-1:0]      fwd_way;
  line_t                 fwd_line;

  logic [STAMP_BITS-1:0] access_clock;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;
  logic [CNT_W-1:0]      eviction_total;
  logic [CNT_W-1:0]      hit_total_next;
  logic [CNT_W-1:0]      miss_total_next;
  logic [CNT_W-1:0]      eviction_total_next;

  logic                  hit_any;
  logic                  empty_any;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      empty_way;
  logic [WAY_W-1:0]      old_way;
  logic [WAYS-1:0]       oldest;
  logic [WAY_W-1:0]      sel_way;
  logic [OUTCOME_W-1:0]  sel_outcome;
  line_t                 wr_line;
  logic                  commit;
  logic                  do_pop;

  logic                  res_valid;
  logic [OUTCOME_W-1:0]  res_outcome;
  logic [OUT_WAY_W-1:0]  res_way;
  logic [CNT_W-1:0]      res_hits;
  logic [CNT_W-1:0]      res_misses;
  logic [CNT_W-1:0]      res_evictions;
  logic                  res_last;

  // Clamp the way count
  always_comb begin
    if (ways_in_use == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_in_use) > WAYS) begin
      ways_eff = WCNT_W'(WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_in_use);
    end
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (w < int'(ways_eff));
    end
  end

  // Handshake and sequencing
  assign clearing  = (state == ST_CLEAR);
  assign commit    = (state == ST_DECIDE) && (!res_valid || res.ready);
  assign pop_ready = (state == ST_IDLE) || commit;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  state_next = (clear_idx == SET_W'(NUM_SETS - 1)) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_next = do_pop ? ST_EVAL : ST_IDLE;
      ST_EVAL:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (commit) begin
          state_next = do_pop ? ST_EVAL : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Set counter of the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
    end else if (clearing) begin
      clear_idx <= clear_idx + 1'b1;
    end
  end

  // Line RAM, one per way; the set of the queue head is read every cycle
  assign wr_line.valid = 1'b1;
  assign wr_line.tag   = d_tag;
  assign wr_line.stamp = access_clock;

  always_comb begin
    if (clearing) begin
      ram_waddr = clear_idx;
      ram_wdata = '0;
    end else begin
      ram_waddr = d_set;
      ram_wdata = wr_line;
    end
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_way
    salru_ram #(
      .WIDTH (LINE_W),
      .DEPTH (NUM_SETS)
    ) u_line_ram (
      .clk   (clk),
      .we    (clearing || (commit && (sel_way == WAY_W'(g)))),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (head.set_idx),
      .rdata (rd_raw[g])
    );
  end

  // Lookup: tag match, empty ways and ages
  always_comb begin
    line_t cur;
    for (int w = 0; w < WAYS; w++) begin
      cur = line_t'(rd_raw[w]);
      if (fwd_valid && (fwd_set == e_set) && (fwd_way == WAY_W'(w))) begin
        cur = fwd_line;
      end
      e_match[w] = in_use[w] && cur.valid && (cur.tag == e_tag);
      e_empty[w] = in_use[w] && !cur.valid;
      e_age[w]   = access_clock - cur.stamp;
    end
  end

  // Lookup and decide registers
  always_ff @(posedge clk) begin
    if (do_pop) begin
      e_set  <= head.set_idx;
      e_tag  <= head.tag;
      e_last <= head.last;
    end
    if (state == ST_EVAL) begin
      d_set    <= e_set;
      d_tag    <= e_tag;
      d_last   <= e_last;
      d_match  <= e_match;
      d_empty  <= e_empty;
      d_in_use <= in_use;
      for (int w = 0; w < WAYS; w++) begin
        d_age[w] <= e_age[w];
      end
    end
  end

  // Lowest matching way and lowest empty way
  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    hit_way   = '0;
    empty_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (d_match[w] && !hit_any) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (d_empty[w] && !empty_any) begin
        empty_any = 1'b1;
        empty_way = WAY_W'(w);
      end
    end
  end

  // Oldest way: strictly older than lower ways, at least as old as higher ones
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      oldest[w] = d_in_use[w];
      for (int j = 0; j < WAYS; j++) begin
        if (d_in_use[j] && (j < w) && (d_age[w] <= d_age[j])) begin
          oldest[w] = 1'b0;
        end
        if (d_in_use[j] && (j > w) && (d_age[w] < d_age[j])) begin
          oldest[w] = 1'b0;
        end
      end
    end
    old_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (oldest[w]) begin
        old_way = WAY_W'(w);
      end
    end
  end

  // Outcome and running totals
  always_comb begin
    hit_total_next      = hit_total;
    miss_total_next     = miss_total;
    eviction_total_next = eviction_total;
    priority if (hit_any) begin
      sel_outcome    = OUT_HIT;
      sel_way        = hit_way;
      hit_total_next = sat_inc(hit_total);
    end else if (empty_any) begin
      sel_outcome     = OUT_FILL;
      sel_way         = empty_way;
      miss_total_next = sat_inc(miss_total);
    end else begin
      sel_outcome         = OUT_EVICT;
      sel_way             = old_way;
      miss_total_next     = sat_inc(miss_total);
      eviction_total_next = sat_inc(eviction_total);
    end
  end

  // Clock, totals, bypass flag and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      access_clock   <= '0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
      fwd_valid      <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      fwd_valid <= commit;
      if (commit) begin
        access_clock   <= access_clock + 1'b1;
        hit_total      <= hit_total_next;
        miss_total     <= miss_total_next;
        eviction_total <= eviction_total_next;
        res_valid      <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Bypass line and result payload
  always_ff @(posedge clk) begin
    if (commit) begin
      fwd_set       <= d_set;
      fwd_way       <= sel_way;
      fwd_line      <= wr_line;
      res_outcome   <= sel_outcome;
      res_way       <= OUT_WAY_W'(sel_way);
      res_hits      <= hit_total_next;
      res_misses    <= miss_total_next;
      res_evictions <= eviction_total_next;
      res_last      <= d_last;
    end
  end

  assign res.valid            = res_valid;
  assign res.outcome          = res_outcome;
  assign res.way_used         = res_way;
  assign res.hits_so_far      = res_hits;
  assign res.misses_so_far    = res_misses;
  assign res.evictions_so_far = res_evictions;
  assign res.last             = res_last;

endmodule
`default_nettype wire

// ===== rtl/core/set_associative_lru_cache_model.sv =====
`default_nettype none
// Set-associative cache model with true LRU replacement (64 sets x 8 ways,
// 64-bit tags, 32-bit stamps). Each load or store makes one access and each
// modify makes two to the same address; every access returns one result with
// its outcome, the way used and saturating hit/miss/eviction totals, with last
// set on the final result of an item. Op code 3 is accepted and dropped. A
// front stage splits the address into set and tag and feeds a two-entry queue;
// the back end reads the set from per-way line RAMs (valid, tag, stamp),
// compares in the next cycle and writes back in the decide state, which waits
// while a result is stalled. The read of the next access overlaps the
// write-back, but only one access at a time is looked up and decided, so the
// back end takes no new access from the queue until the last one commits.
// After reset a clearing pass marks every line invalid; items are queued
// meanwhile but no result comes before it ends. Config writes are always ready
// and must only happen while the block is idle.
module set_associative_lru_cache_model (
  input  logic        clk,
  input  logic        rst,
  salru_cfg_if.sink   cfg,
  salru_req_if.sink   req,
  salru_res_if.source res
);
  import salru_pkg::*;

  logic [SB_W-1:0]  set_bits;
  logic [BB_W-1:0]  block_bits;
  logic [WIU_W-1:0] ways_in_use;

  logic             push_valid;
  logic             push_ready;
  access_t          push_data;
  logic             pop_valid;
  logic             pop_ready;
  access_t          pop_data;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= '0;
      block_bits  <= '0;
      ways_in_use <= WIU_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SET_BITS:    set_bits    <= cfg.data[SB_W-1:0];
        REG_BLOCK_BITS:  block_bits  <= cfg.data[BB_W-1:0];
        REG_WAYS_IN_USE: ways_in_use <= cfg.data[WIU_W-1:0];
        default:         ;
      endcase
    end
  end

  salru_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .set_bits   (set_bits),
    .block_bits (block_bits),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  salru_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  salru_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ways_in_use (ways_in_use),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .head        (pop_data),
    .res         (res)
  );

endmodule
`default_nettype wire

// ===== rtl/core/salru_chk.sv =====
`default_nettype none
`include "set_associative_lru_cache_model_defines.svh"
module salru_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [salru_pkg::OUTCOME_W-1:0] res_outcome,
  input logic [salru_pkg::OUT_WAY_W-1:0] res_way_used,
  input logic [salru_pkg::CNT_W-1:0]     hits,
  input logic [salru_pkg::CNT_W-1:0]     misses,
  input logic [salru_pkg::CNT_W-1:0]     evictions,
  input logic                            res_last
);
  import salru_pkg::*;

  // A stalled result holds
  `SALRU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_outcome) && $stable(res_way_used) && $stable(hits) && $stable(misses) && $stable(evictions) && $stable(res_last), "result changed while stalled")

  // Nothing is offered right after reset
  `SALRU_ASSERT_ALWAYS(a_rst_quiet, $past(rst), !res_valid, "result offered right after reset")

  // The hit total of a reported hit already includes this access
  `SALRU_ASSERT(a_hit_counted, res_valid && (res_outcome == OUT_HIT), hits != '0, "hit not counted")

  // Every eviction is also a miss
  `SALRU_ASSERT(a_evict_le_miss, res_valid, evictions <= misses, "evictions exceed misses")

endmodule

bind set_associative_lru_cache_model salru_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_outcome  (res.outcome),
  .res_way_used (res.way_used),
  .hits         (res.hits_so_far),
  .misses       (res.misses_so_far),
  .evictions    (res.evictions_so_far),
  .res_last     (res.last)
);
`default_nettype wire
